### rtl/dalu_pkg.sv
package dalu_pkg;

   localparam int DIGIT_WIDTH = 8;
   localparam int COUNT_WIDTH = $clog2(DIGIT_WIDTH);
   localparam int HALF_STEPS  = DIGIT_WIDTH / 2;

   typedef logic [DIGIT_WIDTH-1:0] digit_type;
   typedef logic [3:0]             op_type;
   typedef logic [2:0]             status_type;

   localparam op_type OP_AND = 4'd0;
   localparam op_type OP_OR  = 4'd1;
   localparam op_type OP_NOT = 4'd2;
   localparam op_type OP_NEG = 4'd3;
   localparam op_type OP_CMP = 4'd4;
   localparam op_type OP_ADD = 4'd5;
   localparam op_type OP_INC = 4'd6;
   localparam op_type OP_SUB = 4'd7;
   localparam op_type OP_MUL = 4'd8;
   localparam op_type OP_DIV = 4'd9;
   localparam op_type OP_MOD = 4'd10;
   localparam op_type OP_SHL = 4'd11;
   localparam op_type OP_SHR = 4'd12;
   localparam op_type OP_ASR = 4'd13;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_CARRY     = 3'd1;
   localparam status_type ST_BORROW    = 3'd2;
   localparam status_type ST_DIV_ZERO  = 3'd3;
   localparam status_type ST_MOD_ZERO  = 3'd4;
   localparam status_type ST_SHIFT_BIG = 3'd5;
   localparam status_type ST_ONE_WORD  = 3'd6;
   localparam status_type ST_TWO_WORD  = 3'd7;

   localparam logic signed [1:0] ORD_LESS    = -2'sd1;
   localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
   localparam logic signed [1:0] ORD_GREATER = 2'sd1;

endpackage

### rtl/digit_alu_with_spill_shift.sv
// Eight-bit digit ALU: logic, add/inc/sub, 8x8 multiply, divide/modulus and
// spill/fill shifts. One beat is taken every cycle (busy never rises). Its
// result passes the stage 1, stage 2 and output registers and is driven on
// the rsp_ ports, marked by rsp_strobe for one cycle; results leave in order.
// The receiver cannot stall. The pipeline depth is set by the restoring
// divider, four quotient bits in each of the first two stages, then the
// output register.
module digit_alu_with_spill_shift (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dalu_pkg::op_type              req_op,
   input  dalu_pkg::digit_type           req_operand_a,
   input  dalu_pkg::digit_type           req_operand_b,
   input  logic [7:0]                    req_shift_count,
   input  dalu_pkg::digit_type           req_spill_in,
   input  dalu_pkg::digit_type           req_fill_in,
   output logic                          rsp_strobe,
   output dalu_pkg::digit_type           rsp_result_low,
   output dalu_pkg::digit_type           rsp_result_high,
   output dalu_pkg::digit_type           rsp_fill_out,
   output logic signed [1:0]             rsp_order,
   output logic                          rsp_a_is_zero,
   output dalu_pkg::status_type          rsp_status
);

   localparam int DW = dalu_pkg::DIGIT_WIDTH;
   localparam int HS = dalu_pkg::HALF_STEPS;

   // stage 1
   logic                    s1_valid_ff, s1_valid_in;
   dalu_pkg::op_type        s1_op_ff;
   dalu_pkg::digit_type     s1_lo_ff, s1_lo_in;
   dalu_pkg::digit_type     s1_hi_ff, s1_hi_in;
   dalu_pkg::digit_type     s1_fo_ff, s1_fo_in;
   dalu_pkg::status_type    s1_st_ff, s1_st_in;
   logic signed [1:0]       s1_ord_ff, s1_ord_in;
   logic                    s1_az_ff;
   logic                    s1_bz_ff;
   dalu_pkg::digit_type     s1_b_ff;
   dalu_pkg::digit_type     s1_rem_ff, s1_rem_in;
   logic [HS-1:0]           s1_qh_ff, s1_qh_in;
   logic [HS-1:0]           s1_alo_ff;

   // stage 2
   logic                    s2_valid_ff;
   dalu_pkg::digit_type     s2_lo_ff, s2_lo_in;
   dalu_pkg::digit_type     s2_hi_ff, s2_hi_in;
   dalu_pkg::digit_type     s2_fo_ff;
   dalu_pkg::status_type    s2_st_ff, s2_st_in;
   logic signed [1:0]       s2_ord_ff;
   logic                    s2_az_ff;

   // stage 3 (output)
   logic                    s3_valid_ff;
   dalu_pkg::digit_type     s3_lo_ff, s3_hi_ff, s3_fo_ff;
   dalu_pkg::status_type    s3_st_ff;
   logic signed [1:0]       s3_ord_ff;
   logic                    s3_az_ff;

   assign busy        = 1'b0;
   assign s1_valid_in = start & ~busy;

   // stage 1: everything but the second half of the divider
   always_comb begin
      logic [DW:0]             sum;
      logic [2*DW-1:0]         prod;
      logic [2*DW-1:0]         sh_lo, sh_hi, sh_fo;
      logic [dalu_pkg::COUNT_WIDTH-1:0] cnt;
      logic                    big;
      dalu_pkg::digit_type     fill;
      logic [DW:0]             trial;
      dalu_pkg::digit_type     rem;

      sum   = '0;
      prod  = '0;
      sh_lo = '0;
      sh_hi = '0;
      sh_fo = '0;
      cnt   = req_shift_count[dalu_pkg::COUNT_WIDTH-1:0];
      big   = req_shift_count > 8'(DW - 1);
      fill  = req_fill_in;
      s1_lo_in = '0;
      s1_hi_in = '0;
      s1_fo_in = '0;
      s1_st_in = dalu_pkg::ST_OK;

      if (req_operand_a < req_operand_b) begin
         s1_ord_in = dalu_pkg::ORD_LESS;
      end else if (req_operand_a > req_operand_b) begin
         s1_ord_in = dalu_pkg::ORD_GREATER;
      end else begin
         s1_ord_in = dalu_pkg::ORD_EQUAL;
      end

      case (req_op)
         dalu_pkg::OP_AND: begin
            s1_lo_in = req_operand_a & req_operand_b;
         end
         dalu_pkg::OP_OR: begin
            s1_lo_in = req_operand_a | req_operand_b;
         end
         dalu_pkg::OP_NOT: begin
            s1_lo_in = ~req_operand_a;
         end
         dalu_pkg::OP_NEG: begin
            s1_lo_in = -req_operand_a;
         end
         dalu_pkg::OP_ADD: begin
            sum      = {1'b0, req_operand_a} + {1'b0, req_operand_b};
            s1_lo_in = sum[DW-1:0];
            if (sum[DW]) begin
               s1_st_in = dalu_pkg::ST_CARRY;
            end
         end
         dalu_pkg::OP_INC: begin
            s1_lo_in = req_operand_a + dalu_pkg::digit_type'(1);
            if (&req_operand_a) begin
               s1_st_in = dalu_pkg::ST_CARRY;
            end
         end
         dalu_pkg::OP_SUB: begin
            s1_lo_in = req_operand_a - req_operand_b;
            if (req_operand_b > req_operand_a) begin
               s1_st_in = dalu_pkg::ST_BORROW;
            end
         end
         dalu_pkg::OP_MUL: begin
            prod     = {{DW{1'b0}}, req_operand_a} * {{DW{1'b0}}, req_operand_b};
            s1_lo_in = prod[DW-1:0];
            s1_hi_in = prod[2*DW-1:DW];
            s1_st_in = (prod[2*DW-1:DW] == '0) ? dalu_pkg::ST_ONE_WORD
                                               : dalu_pkg::ST_TWO_WORD;
         end
         dalu_pkg::OP_SHL, dalu_pkg::OP_SHR, dalu_pkg::OP_ASR: begin
            if (req_op == dalu_pkg::OP_ASR) begin
               fill = {DW{req_operand_a[DW-1]}};
            end
            if (big) begin
               s1_st_in = dalu_pkg::ST_SHIFT_BIG;
               s1_lo_in = req_operand_a;
               s1_hi_in = req_spill_in;
               s1_fo_in = (req_op == dalu_pkg::OP_ASR) ? '0 : req_fill_in;
            end else if (req_op == dalu_pkg::OP_SHL) begin
               sh_lo    = {req_operand_a, fill} << cnt;
               sh_hi    = {req_spill_in, req_operand_a} << cnt;
               sh_fo    = {{DW{1'b0}}, fill} << cnt;
               s1_lo_in = sh_lo[2*DW-1:DW];
               s1_hi_in = sh_hi[2*DW-1:DW];
               s1_fo_in = sh_fo[2*DW-1:DW];
            end else begin
               sh_lo    = {fill, req_operand_a} >> cnt;
               sh_hi    = {req_operand_a, req_spill_in} >> cnt;
               sh_fo    = {fill, {DW{1'b0}}} >> cnt;
               s1_lo_in = sh_lo[DW-1:0];
               s1_hi_in = sh_hi[DW-1:0];
               s1_fo_in = (req_op == dalu_pkg::OP_ASR) ? '0 : sh_fo[DW-1:0];
            end
         end
         default: begin
         end
      endcase

      // divider, upper quotient bits
      rem = '0;
      for (int i = 0; i < HS; i++) begin
         trial = {rem, req_operand_a[DW-1-i]};
         if (trial >= {1'b0, req_operand_b}) begin
            trial = trial - {1'b0, req_operand_b};
            s1_qh_in[HS-1-i] = 1'b1;
         end else begin
            s1_qh_in[HS-1-i] = 1'b0;
         end
         rem = trial[DW-1:0];
      end
      s1_rem_in = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff  <= req_op;
      s1_lo_ff  <= s1_lo_in;
      s1_hi_ff  <= s1_hi_in;
      s1_fo_ff  <= s1_fo_in;
      s1_st_ff  <= s1_st_in;
      s1_ord_ff <= s1_ord_in;
      s1_az_ff  <= (req_operand_a == '0);
      s1_bz_ff  <= (req_operand_b == '0);
      s1_b_ff   <= req_operand_b;
      s1_rem_ff <= s1_rem_in;
      s1_qh_ff  <= s1_qh_in;
      s1_alo_ff <= req_operand_a[HS-1:0];
   end

   // stage 2: lower quotient bits and merge
   always_comb begin
      logic [DW:0]         trial;
      dalu_pkg::digit_type rem;
      logic [HS-1:0]       ql;

      rem = s1_rem_ff;
      ql  = '0;
      for (int i = 0; i < HS; i++) begin
         trial = {rem, s1_alo_ff[HS-1-i]};
         if (trial >= {1'b0, s1_b_ff}) begin
            trial = trial - {1'b0, s1_b_ff};
            ql[HS-1-i] = 1'b1;
         end
         rem = trial[DW-1:0];
      end

      s2_lo_in = s1_lo_ff;
      s2_hi_in = s1_hi_ff;
      s2_st_in = s1_st_ff;
      case (s1_op_ff)
         dalu_pkg::OP_DIV: begin
            if (s1_bz_ff) begin
               s2_st_in = dalu_pkg::ST_DIV_ZERO;
            end else begin
               s2_lo_in = {s1_qh_ff, ql};
               s2_hi_in = rem;
            end
         end
         dalu_pkg::OP_MOD: begin
            if (s1_bz_ff) begin
               s2_st_in = dalu_pkg::ST_MOD_ZERO;
            end else begin
               s2_lo_in = rem;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s2_lo_ff  <= s2_lo_in;
      s2_hi_ff  <= s2_hi_in;
      s2_fo_ff  <= s1_fo_ff;
      s2_st_ff  <= s2_st_in;
      s2_ord_ff <= s1_ord_ff;
      s2_az_ff  <= s1_az_ff;
      s3_lo_ff  <= s2_lo_ff;
      s3_hi_ff  <= s2_hi_ff;
      s3_fo_ff  <= s2_fo_ff;
      s3_st_ff  <= s2_st_ff;
      s3_ord_ff <= s2_ord_ff;
      s3_az_ff  <= s2_az_ff;
   end

   assign rsp_strobe      = s3_valid_ff;
   assign rsp_result_low  = s3_lo_ff;
   assign rsp_result_high = s3_hi_ff;
   assign rsp_fill_out    = s3_fo_ff;
   assign rsp_order       = s3_ord_ff;
   assign rsp_a_is_zero   = s3_az_ff;
   assign rsp_status      = s3_st_ff;

endmodule

### rtl/dalu_checker.sv
module dalu_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  dalu_pkg::op_type     req_op,
   input  dalu_pkg::digit_type  req_operand_a,
   input  dalu_pkg::digit_type  req_operand_b,
   input  logic [7:0]           req_shift_count,
   input  dalu_pkg::digit_type  req_spill_in,
   input  dalu_pkg::digit_type  req_fill_in,
   input  logic                 rsp_strobe,
   input  dalu_pkg::digit_type  rsp_result_low,
   input  dalu_pkg::digit_type  rsp_result_high,
   input  dalu_pkg::digit_type  rsp_fill_out,
   input  logic signed [1:0]    rsp_order,
   input  logic                 rsp_a_is_zero,
   input  dalu_pkg::status_type rsp_status
);

   // every accepted beat answers with rsp_strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("accepted beat gave no result");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start, 3) && !$past(busy, 3)))
      else $error("result without accepted beat");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_a_is_zero == ($past(req_operand_a, 3) == '0)))
      else $error("a_is_zero mismatch");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == dalu_pkg::ST_DIV_ZERO
                      || rsp_status == dalu_pkg::ST_MOD_ZERO))
      |-> (rsp_result_low == '0 && rsp_result_high == '0
           && $past(req_operand_b, 3) == '0))
      else $error("zero divisor result not cleared");

endmodule

bind digit_alu_with_spill_shift dalu_checker u_dalu_checker (.*);

### bench/tb_digit_alu_with_spill_shift.sv
module tb_digit_alu_with_spill_shift;
   timeunit 1ns;
   timeprecision 1ps;

   import dalu_pkg::*;

   typedef logic signed [1:0] order_type;

   typedef struct packed {
      digit_type  low;
      digit_type  high;
      digit_type  fill;
      order_type  order;
      logic       a_zero;
      status_type status;
   } alu_answer_t;

   class alu_scoreboard;
      alu_answer_t pending_answers[$];
      int          mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction

      function void report(string what, int got, int want);
         if (mismatches < 60)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
         mismatches++;
      endfunction

      function alu_answer_t predict(op_type op, digit_type a, digit_type b,
                                    logic [7:0] count, digit_type spill,
                                    digit_type fill);
         alu_answer_t r;
         logic [8:0]  sum;
         logic [15:0] product;
         digit_type   fill_bits;
         int          back;
         r = '0;
         fill_bits = fill;
         r.order = (a < b) ? ORD_LESS : (a > b) ? ORD_GREATER : ORD_EQUAL;
         r.a_zero = (a == 8'h00);
         r.status = ST_OK;
         case (op)
            OP_AND: r.low = a & b;
            OP_OR:  r.low = a | b;
            OP_NOT: r.low = ~a;
            OP_NEG: r.low = 8'h00 - a;
            OP_CMP: r.low = 8'h00;
            OP_ADD: begin
               sum = {1'b0, a} + {1'b0, b};
               r.low = sum[7:0];
               if (sum[8]) r.status = ST_CARRY;
            end
            OP_INC: begin
               r.low = a + 8'h01;
               if (r.low == 8'h00) r.status = ST_CARRY;
            end
            OP_SUB: begin
               r.low = a - b;
               if (b > a) r.status = ST_BORROW;
            end
            OP_MUL: begin
               product = a * b;
               r.low = product[7:0];
               r.high = product[15:8];
               r.status = (product[15:8] == 8'h00) ? ST_ONE_WORD : ST_TWO_WORD;
            end
            OP_DIV: begin
               if (b == 8'h00) r.status = ST_DIV_ZERO;
               else begin
                  r.low = a / b;
                  r.high = a % b;
               end
            end
            OP_MOD: begin
               if (b == 8'h00) r.status = ST_MOD_ZERO;
               else r.low = a % b;
            end
            OP_SHL, OP_SHR, OP_ASR: begin
               if (op == OP_ASR) fill_bits = a[7] ? 8'hFF : 8'h00;
               if (count > 8'd7) begin
                  r.status = ST_SHIFT_BIG;
                  r.low = a;
                  r.high = spill;
                  r.fill = (op == OP_ASR) ? 8'h00 : fill_bits;
               end else begin
                  back = 8 - int'(count);
                  if (op == OP_SHL) begin
                     r.fill = fill_bits >> back;
                     r.low = (a << count) | r.fill;
                     r.high = (spill << count) + (a >> back);
                  end else begin
                     r.fill = fill_bits << back;
                     r.low = (a >> count) | r.fill;
                     r.high = (spill >> count) + (a << back);
                  end
                  if (op == OP_ASR) r.fill = 8'h00;
               end
            end
            default: r.low = 8'h00;
         endcase
         return r;
      endfunction

      function void note_beat(op_type op, digit_type a, digit_type b,
                              logic [7:0] count, digit_type spill, digit_type fill);
         pending_answers.push_back(predict(op, a, b, count, spill, fill));
      endfunction

      function void check_beat(alu_answer_t got);
         alu_answer_t want;
         if (pending_answers.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
         end
         want = pending_answers.pop_front();
         if (got.low !== want.low) report("result_low", got.low, want.low);
         if (got.high !== want.high) report("result_high", got.high, want.high);
         if (got.fill !== want.fill) report("fill_out", got.fill, want.fill);
         if (got.order !== want.order) report("order", got.order, want.order);
         if (got.a_zero !== want.a_zero) report("a_is_zero", got.a_zero, want.a_zero);
         if (got.status !== want.status) report("status", got.status, want.status);
      endfunction
   endclass

   localparam int RANDOM_BEATS = 1100;
   localparam int CALM_TAIL    = 150;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   op_type     req_op;
   digit_type  req_operand_a;
   digit_type  req_operand_b;
   logic [7:0] req_shift_count;
   digit_type  req_spill_in;
   digit_type  req_fill_in;
   logic       rsp_strobe;
   digit_type  rsp_result_low;
   digit_type  rsp_result_high;
   digit_type  rsp_fill_out;
   order_type  rsp_order;
   logic       rsp_a_is_zero;
   status_type rsp_status;

   alu_scoreboard alu_book;

   digit_alu_with_spill_shift dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .req_shift_count (req_shift_count),
      .req_spill_in    (req_spill_in),
      .req_fill_in     (req_fill_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_low  (rsp_result_low),
      .rsp_result_high (rsp_result_high),
      .rsp_fill_out    (rsp_fill_out),
      .rsp_order       (rsp_order),
      .rsp_a_is_zero   (rsp_a_is_zero),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            alu_book.check_beat('{rsp_result_low, rsp_result_high, rsp_fill_out,
                                  rsp_order, rsp_a_is_zero, rsp_status});
         if (start && !busy)
            alu_book.note_beat(req_op, req_operand_a, req_operand_b,
                               req_shift_count, req_spill_in, req_fill_in);
      end
   end

   // called just after a falling edge; returns just after the next one
   task automatic send_beat(op_type op, digit_type a, digit_type b,
                            logic [7:0] count, digit_type spill, digit_type fill);
      start = 1'b1;
      req_op = op;
      req_operand_a = a;
      req_operand_b = b;
      req_shift_count = count;
      req_spill_in = spill;
      req_fill_in = fill;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(int cycles);
      start = 1'b0;
      repeat (cycles) begin
         req_op = op_type'($urandom_range(0, 15));
         req_operand_a = digit_type'($urandom);
         req_operand_b = digit_type'($urandom);
         req_shift_count = 8'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic drain();
      start = 1'b0;
      while (alu_book.pending() != 0) @(negedge clock);
   endtask

   function automatic digit_type pick_digit();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         4: return 8'h01;
         default: return digit_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_count();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 7));
   endfunction

   task automatic send_random();
      send_beat(op_type'($urandom_range(0, 15)), pick_digit(), pick_digit(),
                pick_count(), pick_digit(), pick_digit());
   endtask

   initial begin
      int guard;
      bit calm;
      alu_book = new();
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_AND;
      req_operand_a = '0;
      req_operand_b = '0;
      req_shift_count = '0;
      req_spill_in = '0;
      req_fill_in = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_beat(OP_AND, 8'hFF, 8'h0F, 8'd0, 8'h00, 8'h00);
      send_beat(OP_OR,  8'hA0, 8'h05, 8'd0, 8'h00, 8'h00);
      send_beat(OP_NOT, 8'h00, 8'hFF, 8'd0, 8'h00, 8'h00);
      send_beat(OP_NEG, 8'h80, 8'h00, 8'd0, 8'h00, 8'h00);
      send_beat(OP_CMP, 8'h10, 8'h20, 8'd0, 8'h00, 8'h00);
      send_beat(OP_CMP, 8'h00, 8'h00, 8'd0, 8'h00, 8'h00);
      send_beat(OP_CMP, 8'hFF, 8'h00, 8'd0, 8'h00, 8'h00);
      send_beat(OP_ADD, 8'hFF, 8'h01, 8'd0, 8'h00, 8'h00);
      send_beat(OP_INC, 8'hFF, 8'h00, 8'd0, 8'h00, 8'h00);
      send_beat(OP_SUB, 8'h00, 8'hFF, 8'd0, 8'h00, 8'h00);
      send_beat(OP_MUL, 8'hFF, 8'hFF, 8'd0, 8'h00, 8'h00);
      send_beat(OP_MUL, 8'h10, 8'h0F, 8'd0, 8'h00, 8'h00);
      send_beat(OP_DIV, 8'hC8, 8'h00, 8'd0, 8'h00, 8'h00);
      send_beat(OP_DIV, 8'hC8, 8'h07, 8'd0, 8'h00, 8'h00);
      send_beat(OP_MOD, 8'hC8, 8'h00, 8'd0, 8'h00, 8'h00);
      send_beat(OP_MOD, 8'hFF, 8'h07, 8'd0, 8'h00, 8'h00);
      send_beat(OP_SHL, 8'hA5, 8'h00, 8'd0, 8'h3C, 8'hFF);
      send_beat(OP_SHL, 8'hFF, 8'h00, 8'd7, 8'hFF, 8'hFF);
      send_beat(OP_SHR, 8'hA5, 8'h00, 8'd3, 8'h81, 8'hC3);
      send_beat(OP_SHR, 8'h5A, 8'h00, 8'd8, 8'h11, 8'h22);
      send_beat(OP_ASR, 8'h80, 8'h00, 8'd1, 8'h0F, 8'h00);
      send_beat(OP_ASR, 8'hF0, 8'h00, 8'd255, 8'h44, 8'h55);
      send_beat(op_type'(14), 8'h12, 8'h34, 8'd0, 8'h00, 8'h00);
      send_beat(op_type'(15), 8'h00, 8'h00, 8'd0, 8'h00, 8'h00);
      drain();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         send_random();
         calm = (i >= RANDOM_BEATS - CALM_TAIL) || ((i / 100) % 3 == 2);
         if (i == RANDOM_BEATS / 2) drain();
         else if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 13));
      end
      start = 1'b0;

      guard = 0;
      while (alu_book.pending() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (alu_book.pending() != 0) alu_book.report("missing beats", 0, alu_book.pending());
      if (alu_book.mismatches == 0) begin
         $display("[digit_alu_with_spill_shift] OK");
      end else begin
         $display("[digit_alu_with_spill_shift] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[digit_alu_with_spill_shift] ERROR");
      $finish;
   end

endmodule
